FILE: rtl/usf_pkg.sv
package usf_pkg;

	localparam int SET_DEPTH_DEF = 64;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_SET   = 2'd1;
	localparam logic [1:0] OP_TEXT  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_MALFORMED = 2'd1;
	localparam logic [1:0] ERR_FULL      = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic decode;
		logic scan_start;
		logic scan_step;
		logic emit_pop;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_scan;
		logic scan_done;
		logic emit_any;
		logic emit_last;
	} stat_t;

	// Bloom hash of a scalar.
	function automatic logic [7:0] bloom_hash(input logic [20:0] s);
		bloom_hash = s[7:0] ^ s[15:8] ^ {3'b000, s[20:16]};
	endfunction

endpackage

FILE: rtl/usf_ctrl.sv
module usf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output usf_pkg::cmd_t    cmd,
	input  usf_pkg::stat_t   stat
);

	usf_pkg::state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= usf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			usf_pkg::ST_IDLE: begin
				if (start) state_d = usf_pkg::ST_DECODE;
			end
			usf_pkg::ST_DECODE: begin
				if (stat.need_scan) state_d = usf_pkg::ST_SCAN;
				else if (stat.emit_any) state_d = usf_pkg::ST_EMIT;
				else state_d = usf_pkg::ST_IDLE;
			end
			usf_pkg::ST_SCAN: begin
				if (stat.scan_done) begin
					state_d = stat.emit_any ? usf_pkg::ST_EMIT : usf_pkg::ST_IDLE;
				end
			end
			usf_pkg::ST_EMIT: begin
				if (stat.emit_last) state_d = usf_pkg::ST_IDLE;
			end
			default: state_d = usf_pkg::ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			usf_pkg::ST_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			usf_pkg::ST_DECODE: begin
				cmd.decode = 1'b1;
				cmd.scan_start = stat.need_scan;
			end
			usf_pkg::ST_SCAN: cmd.scan_step = 1'b1;
			usf_pkg::ST_EMIT: cmd.emit_pop = 1'b1;
			default: busy = 1'b1;
		endcase
	end

endmodule

FILE: rtl/usf_datapath.sv
module usf_datapath #(
	parameter int SET_DEPTH = usf_pkg::SET_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       operation,
	input  logic [7:0]       data_byte,
	input  usf_pkg::cmd_t    cmd,
	output usf_pkg::stat_t   stat,
	output logic             valid,
	output logic [7:0]       out_byte,
	output logic             last_of_scalar,
	output logic [1:0]       error_code
);

	localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int CW = $clog2(SET_DEPTH + 1);

	logic [1:0]   op_q;
	logic [7:0]   byte_q;
	logic [127:0] ascii_q;
	logic [255:0] bloom_q;
	logic [20:0]  table_mem [SET_DEPTH];
	logic [CW-1:0] count_q;
	logic [7:0]   pend_q [3];
	logic [20:0]  part_q;
	logic [1:0]   rem_q, held_q;

	// Result queue: up to four words, played out one a cycle.
	logic [7:0]   qb_q [4];
	logic [3:0]   ql_q;
	logic [1:0]   qe_q [4];
	logic [2:0]   qn_q, qi_q;

	// Scan state.
	logic [20:0]  scal_q;
	logic [CW-1:0] si_q;
	logic [20:0]  rd_q;
	logic         rdv_q;
	logic [7:0]   pk_q [4];
	logic [2:0]   pkn_q;

	// Decode of the latched byte against the decoder state.
	logic [7:0] lo, hi;
	logic       cont_ok, err1, done, is_set;
	logic [20:0] sc;
	logic [7:0] bh;
	logic [20:0] nxt_part;

	always_comb begin
		lo = 8'h80; hi = 8'hBF;
		if (held_q == 2'd1) begin
			if (pend_q[0] == 8'hE0) lo = 8'hA0;
			else if (pend_q[0] == 8'hED) hi = 8'h9F;
			else if (pend_q[0] == 8'hF0) lo = 8'h90;
			else if (pend_q[0] == 8'hF4) hi = 8'h8F;
		end
		cont_ok = (rem_q != 2'd0) && byte_q >= lo && byte_q <= hi;
		err1 = (rem_q != 2'd0) && !cont_ok;
		nxt_part = {part_q[14:0], byte_q[5:0]};
		done = 1'b0; sc = nxt_part;
		if (cont_ok) begin
			done = (rem_q == 2'd1);
		end else if (byte_q < 8'h80) begin
			done = 1'b1; sc = {13'd0, byte_q};
		end
		is_set = (op_q == usf_pkg::OP_SET);
		bh = usf_pkg::bloom_hash(sc);
	end

	logic start_bad;
	assign start_bad = !cont_ok && byte_q >= 8'h80 &&
		!(byte_q >= 8'hC2 && byte_q <= 8'hF4);

	logic act;
	assign act = cmd.decode && (op_q == usf_pkg::OP_SET || op_q == usf_pkg::OP_TEXT);

	logic text_done, ascii_hit, bloom_hit;
	assign text_done = act && done && !is_set;
	assign ascii_hit = ascii_q[sc[6:0]];
	assign bloom_hit = bloom_q[bh];

	// Number of words queued by the decode step.
	logic [2:0] qn_d;

	assign stat.need_scan = text_done && (sc >= 21'h80) && bloom_hit;
	assign stat.scan_done = cmd.scan_step && (rdv_q && (rd_q == scal_q) ||
		(si_q >= count_q && !rdv_q));
	assign stat.emit_any = cmd.scan_step ? (!(rdv_q && rd_q == scal_q) || pkn_q == 3'd0)
		&& (qn_q != 3'd0 || !(rdv_q && rd_q == scal_q)) : (qn_d != 3'd0);
	assign stat.emit_last = (qi_q + 3'd1 >= qn_q);

	// Words queued by the decode step, before any scan.
	logic [7:0] nb [4];
	logic [3:0] nl;
	logic [1:0] ne [4];
	logic [2:0] nn;
	logic       keep;
	always_comb begin
		nn = 3'd0; nl = '0;
		for (int i = 0; i < 4; i++) begin nb[i] = 8'd0; ne[i] = usf_pkg::ERR_NONE; end
		if (err1 || start_bad) begin
			nb[0] = 8'd0; nl[0] = 1'b1; ne[0] = usf_pkg::ERR_MALFORMED; nn = 3'd1;
		end
		if (err1 && start_bad) begin
			nl[1] = 1'b1; ne[1] = usf_pkg::ERR_MALFORMED; nn = 3'd2;
		end
		if (act && done && is_set && sc >= 21'h80 && count_q >= CW'(SET_DEPTH)) begin
			nl[nn[1:0]] = 1'b1; ne[nn[1:0]] = usf_pkg::ERR_FULL; nn = nn + 3'd1;
		end
		keep = (sc < 21'h80) ? !ascii_hit : !bloom_hit;
		if (text_done && keep && !(sc >= 21'h80 && bloom_hit)) begin
			if (cont_ok) begin
				for (int i = 0; i < 3; i++) begin
					if (2'(i) < held_q) begin nb[nn[1:0]] = pend_q[i]; nn = nn + 3'd1; end
				end
			end
			nb[nn[1:0]] = byte_q; nl[nn[1:0]] = 1'b1; nn = nn + 3'd1;
		end
		qn_d = act ? nn : 3'd0;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ascii_q <= '0; bloom_q <= '0; count_q <= '0;
			part_q <= '0; rem_q <= '0; held_q <= '0;
			qn_q <= '0; qi_q <= '0; si_q <= '0; rdv_q <= 1'b0; pkn_q <= '0;
		end else begin
			if (cmd.decode && op_q == usf_pkg::OP_CLEAR) begin
				ascii_q <= '0; bloom_q <= '0; count_q <= '0;
				part_q <= '0; rem_q <= '0; held_q <= '0;
			end else if (act) begin
				if (done) begin
					part_q <= '0; rem_q <= '0; held_q <= '0;
					if (is_set) begin
						if (sc < 21'h80) ascii_q[sc[6:0]] <= 1'b1;
						else if (count_q < CW'(SET_DEPTH)) begin
							count_q <= count_q + 1'b1;
							bloom_q[bh] <= 1'b1;
						end
					end
				end else if (cont_ok) begin
					part_q <= nxt_part; rem_q <= rem_q - 2'd1;
					if (held_q < 2'd3) held_q <= held_q + 2'd1;
				end else if (byte_q >= 8'hC2 && byte_q <= 8'hDF) begin
					rem_q <= 2'd1; part_q <= {16'd0, byte_q[4:0]}; held_q <= 2'd1;
				end else if (byte_q >= 8'hE0 && byte_q <= 8'hEF) begin
					rem_q <= 2'd2; part_q <= {17'd0, byte_q[3:0]}; held_q <= 2'd1;
				end else if (byte_q >= 8'hF0 && byte_q <= 8'hF4) begin
					rem_q <= 2'd3; part_q <= {18'd0, byte_q[2:0]}; held_q <= 2'd1;
				end else begin
					part_q <= '0; rem_q <= '0; held_q <= '0;
				end
			end
			if (cmd.decode) begin
				qn_q <= qn_d; qi_q <= '0;
			end
			if (cmd.scan_start) begin
				si_q <= '0; rdv_q <= 1'b0;
				pkn_q <= cont_ok ? {1'b0, held_q} + 3'd1 : 3'd1;
			end
			if (cmd.scan_step) begin
				rdv_q <= (si_q < count_q);
				if (si_q < count_q) si_q <= si_q + 1'b1;
				if (stat.scan_done && !(rdv_q && rd_q == scal_q)) begin
					qn_q <= qn_q + pkn_q; qi_q <= '0;
				end
			end
			if (cmd.emit_pop) qi_q <= qi_q + 3'd1;
		end
	end

	// Payload registers, memory and queue contents.
	always_ff @(posedge clk) begin
		if (cmd.load) begin op_q <= operation; byte_q <= data_byte; end
		if (act && !done && cont_ok && held_q < 2'd3) pend_q[held_q] <= byte_q;
		if (act && !cont_ok) pend_q[0] <= byte_q;
		if (act && done && is_set && sc >= 21'h80 && count_q < CW'(SET_DEPTH))
			table_mem[count_q[AW-1:0]] <= sc;
		if (cmd.scan_step) rd_q <= table_mem[si_q[AW-1:0]];
		if (cmd.decode) begin
			for (int i = 0; i < 4; i++) begin
				qb_q[i] <= nb[i]; qe_q[i] <= ne[i]; ql_q[i] <= nl[i];
			end
			scal_q <= sc;
		end
		// Held bytes of the scanned scalar, closed by the current byte.
		if (cmd.scan_start) begin
			for (int i = 0; i < 3; i++) pk_q[i] <= (2'(i) == held_q) ? byte_q : pend_q[i];
			pk_q[3] <= byte_q;
		end
		if (cmd.scan_step && stat.scan_done && !(rdv_q && rd_q == scal_q)) begin
			for (int i = 0; i < 4; i++) begin
				if (3'(i) >= qn_q && 3'(i) < qn_q + pkn_q) begin
					qb_q[i] <= pk_q[2'(3'(i) - qn_q)];
					qe_q[i] <= usf_pkg::ERR_NONE;
					ql_q[i] <= (3'(i) == qn_q + pkn_q - 3'd1);
				end
			end
		end
	end

	// Result words.
	assign valid = cmd.emit_pop;
	assign out_byte = qb_q[qi_q[1:0]];
	assign last_of_scalar = ql_q[qi_q[1:0]];
	assign error_code = qe_q[qi_q[1:0]];

endmodule

FILE: rtl/utf8_scalar_set_filter.sv
// Start loads the byte and the decode state follows; the result words then come one word a cycle.
// A non-ASCII text scalar that hits the Bloom map adds a table scan before its result words.
// A new byte is taken only once the results of the last one are out; start is taken while busy is low.
// Reset: arst_n clears bitmaps, set count and decoder at once; table contents stay undefined.
// The receiver cannot stall: each word shows for one cycle with strobe high.
module utf8_scalar_set_filter #(
	parameter int SET_DEPTH = usf_pkg::SET_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] operation,
	input  logic [7:0] data_byte,
	output logic       strobe,
	output logic [7:0] out_byte,
	output logic       last_of_scalar,
	output logic [1:0] error_code
);

	usf_pkg::cmd_t  cmd;
	usf_pkg::stat_t stat;

	// Sequencer.
	usf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .stat(stat)
	);

	// Decoder, stores and result queue.
	usf_datapath #(.SET_DEPTH(SET_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .operation(operation), .data_byte(data_byte),
		.cmd(cmd), .stat(stat), .valid(strobe), .out_byte(out_byte),
		.last_of_scalar(last_of_scalar), .error_code(error_code)
	);

endmodule

FILE: rtl/usf_checker.sv
module usf_props (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic [7:0] out_byte,
	input logic       last_of_scalar,
	input logic [1:0] error_code
);

	// A word is accepted only when the block is free.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised after start");

	// Results appear only while a word is being worked.
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("strobe while idle");

	// Error results carry a zero byte and close the scalar.
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && error_code != usf_pkg::ERR_NONE |-> out_byte == 8'd0 && last_of_scalar)
		else $error("bad error result");

	// The block goes idle only after the closing word.
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_of_scalar |=> busy) else $error("idle mid scalar");

endmodule

bind utf8_scalar_set_filter usf_props u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .strobe(strobe),
	.out_byte(out_byte), .last_of_scalar(last_of_scalar), .error_code(error_code)
);
